### src/qped_pkg.sv
// ----------------------------------------------------------------------------
// qped_pkg
// Types, character codes and helper functions for the query parameter
// extract and decode unit.
// ----------------------------------------------------------------------------
package qped_pkg;

   // input transaction
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_query;
   } req_payload_type;

   // result transaction
   typedef struct packed {
      logic [7:0] value_byte;
      logic       byte_valid;
      logic       found;
      logic       done_res;
   } rsp_payload_type;

   // parser phase
   typedef enum logic [2:0] {
      PH_KEY_START = 3'd0,
      PH_KEY       = 3'd1,
      PH_SKIP      = 3'd2,
      PH_VALUE     = 3'd3,
      PH_ESC1      = 3'd4,
      PH_ESC2      = 3'd5
   } phase_type;

   // register indexes
   localparam logic CSR_NAME_CHARS  = 1'b0;
   localparam logic CSR_NAME_LENGTH = 1'b1;

   localparam int CSR_DATA_WIDTH = 64;
   localparam int NAME_LEN_WIDTH = 4;

   // character codes
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   // returns {digit valid, digit value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

### src/query_param_extract_decode_unit.sv
// ----------------------------------------------------------------------------
// query_param_extract_decode_unit
// Scans a URL query string one byte per transaction, finds the configured
// parameter name (ASCII case ignored) and streams its percent-decoded value.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid, req_stall, req_payload       | in
//  result  | rsp_valid, rsp_stall, rsp_payload       | out
//  csr     | csr_wr_en, csr_index, csr_wdata         | in
//
//  One byte per cycle while req_stall is low: the parser state and the result
//  register update in the same cycle a byte is accepted, so a result appears in the cycle after its byte.
//  Synchronous reset returns the parser to the start of a query and loads the
//  name registers with a name of one zero byte.
//  req_stall is high only while a result sits in the output register and the
//  result side stalls; a byte with no result still advances the parser.
// ----------------------------------------------------------------------------
module query_param_extract_decode_unit
   import qped_pkg::*;
#(
   parameter int MAX_NAME_CHARS = 8
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  req_payload_type                   req_payload,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rsp_payload_type                   rsp_payload,

   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]         csr_wdata
);

   localparam int NAME_BITS = MAX_NAME_CHARS * 8;
   localparam logic [NAME_LEN_WIDTH-1:0] MAX_LEN = NAME_LEN_WIDTH'(MAX_NAME_CHARS);

   // configuration
   logic [NAME_BITS-1:0]      name_chars_ff;
   logic [NAME_LEN_WIDTH-1:0] name_length_ff;

   // parser state
   phase_type  phase_ff, phase_in;
   logic [3:0] key_pos_ff, key_pos_in;
   logic       key_match_ff, key_match_in;
   logic [7:0] esc_value_ff, esc_value_in;
   logic       esc_digit_ff, esc_digit_in;
   logic       answered_ff, answered_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic       req_accept;
   logic       rsp_load;
   logic [3:0] eff_len;
   logic [7:0] c;
   logic       last;
   logic       have, fin, fnd;
   logic [7:0] ob;
   logic [3:0] kc_pos;
   logic       kc_base;
   logic [7:0] want;
   logic [4:0] hex;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign c          = req_payload.in_byte;
   assign last       = req_payload.end_of_query;
   assign eff_len    = (name_length_ff > MAX_LEN) ? MAX_LEN : name_length_ff;
   assign hex        = hex_digit(c);

   // name character at the key position
   always_comb begin
      kc_pos  = (phase_ff == PH_KEY_START) ? 4'd0 : key_pos_ff;
      kc_base = (phase_ff == PH_KEY_START) ? 1'b1 : key_match_ff;
      want    = 8'd0;
      for (int i = 0; i < MAX_NAME_CHARS; i++) begin
         if (kc_pos == 4'(i)) begin
            want = name_chars_ff[i*8 +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_chars_ff  <= '0;
         name_length_ff <= NAME_LEN_WIDTH'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NAME_CHARS:  name_chars_ff  <= csr_wdata[NAME_BITS-1:0];
            CSR_NAME_LENGTH: name_length_ff <= csr_wdata[NAME_LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_KEY_START;
         key_pos_ff   <= 4'd0;
         key_match_ff <= 1'b1;
         esc_value_ff <= 8'd0;
         esc_digit_ff <= 1'b0;
         answered_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         key_pos_ff   <= key_pos_in;
         key_match_ff <= key_match_in;
         esc_value_ff <= esc_value_in;
         esc_digit_ff <= esc_digit_in;
         answered_ff  <= answered_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      phase_in     = phase_ff;
      key_pos_in   = key_pos_ff;
      key_match_in = key_match_ff;
      esc_value_in = esc_value_ff;
      esc_digit_in = esc_digit_ff;
      answered_in  = answered_ff;
      have         = 1'b0;
      fin          = 1'b0;
      fnd          = 1'b0;
      ob           = 8'd0;

      if (answered_ff) begin
         if (last) begin
            phase_in     = PH_KEY_START;
            key_pos_in   = 4'd0;
            key_match_in = 1'b1;
            esc_value_in = 8'd0;
            esc_digit_in = 1'b0;
            answered_in  = 1'b0;
         end
      end else begin
         unique case (phase_ff) inside
            PH_KEY_START, PH_KEY: begin
               if (phase_ff == PH_KEY && c == CH_AMP) begin
                  if (key_match_ff && key_pos_ff == eff_len) begin
                     fin = 1'b1;
                     fnd = 1'b1;
                  end else begin
                     phase_in = PH_KEY_START;
                  end
               end else if (phase_ff == PH_KEY && c == CH_EQ) begin
                  phase_in = (key_match_ff && key_pos_ff == eff_len) ? PH_VALUE : PH_SKIP;
               end else if (!(phase_ff == PH_KEY_START && (c == CH_AMP || c == CH_EQ))) begin
                  // compare one key character
                  phase_in     = PH_KEY;
                  key_match_in = kc_base && (kc_pos < eff_len)
                                 && (lower_ascii(want) == lower_ascii(c));
                  key_pos_in   = (kc_pos == 4'd15) ? kc_pos : kc_pos + 4'd1;
               end
            end
            PH_SKIP: begin
               if (c == CH_AMP) begin
                  phase_in = PH_KEY_START;
               end
            end
            PH_VALUE: begin
               if (c == CH_AMP || c == CH_NUL) begin
                  fin = 1'b1;
                  fnd = 1'b1;
               end else if (c == CH_PLUS) begin
                  ob   = CH_SPACE;
                  have = 1'b1;
                  fnd  = 1'b1;
               end else if (c == CH_PCT) begin
                  esc_value_in = 8'd0;
                  esc_digit_in = 1'b0;
                  phase_in     = PH_ESC1;
               end else begin
                  ob   = c;
                  have = 1'b1;
                  fnd  = 1'b1;
               end
            end
            PH_ESC1: begin
               if (c == CH_AMP) begin
                  fin = 1'b1;
                  fnd = 1'b1;
               end else begin
                  esc_value_in = hex[4] ? {4'd0, hex[3:0]} : 8'd0;
                  esc_digit_in = hex[4];
                  phase_in     = PH_ESC2;
               end
            end
            PH_ESC2: begin
               fnd = 1'b1;
               if (c == CH_AMP) begin
                  fin = 1'b1;
                  if (esc_value_ff != 8'd0) begin
                     ob   = esc_value_ff;
                     have = 1'b1;
                  end
               end else begin
                  if (esc_digit_ff && hex[4]) begin
                     esc_value_in = {esc_value_ff[3:0], hex[3:0]};
                  end
                  phase_in = PH_VALUE;
                  // decoded zero ends the value
                  if (esc_value_in == 8'd0) begin
                     fin = 1'b1;
                  end else begin
                     ob   = esc_value_in;
                     have = 1'b1;
                  end
               end
            end
            default: ;
         endcase

         // end of query closes whatever is open
         if (last && !fin) begin
            fin = 1'b1;
            case (phase_in) inside
               PH_KEY:            fnd = key_match_in && (key_pos_in == eff_len);
               PH_VALUE, PH_ESC1: fnd = 1'b1;
               PH_ESC2: begin
                  fnd = 1'b1;
                  if (esc_value_in != 8'd0) begin
                     ob   = esc_value_in;
                     have = 1'b1;
                  end
               end
               default:           fnd = 1'b0;
            endcase
         end

         if (fin) begin
            if (last) begin
               phase_in     = PH_KEY_START;
               key_pos_in   = 4'd0;
               key_match_in = 1'b1;
               esc_value_in = 8'd0;
               esc_digit_in = 1'b0;
               answered_in  = 1'b0;
            end else begin
               answered_in = 1'b1;
            end
         end
      end

      // hold the parser state when no transaction is taken
      if (!req_accept) begin
         phase_in     = phase_ff;
         key_pos_in   = key_pos_ff;
         key_match_in = key_match_ff;
         esc_value_in = esc_value_ff;
         esc_digit_in = esc_digit_ff;
         answered_in  = answered_ff;
      end
   end

   assign rsp_load = req_accept & (have | fin);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.value_byte = have ? ob : 8'd0;
         rsp_payload_in.byte_valid = have;
         rsp_payload_in.found      = fnd;
         rsp_payload_in.done_res   = fin;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTH
   a_byte_implies_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.byte_valid |-> rsp_payload.found)
      else $error("decoded byte without found");

   a_empty_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.byte_valid |-> rsp_payload.value_byte == 8'd0)
      else $error("value_byte not zero on a done-only result");

   a_answered_silent: assert property (@(posedge clock) disable iff (reset)
      req_accept && answered_ff |-> !rsp_load)
      else $error("result produced after the query was answered");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("request stalled while the result register is free");
`endif

endmodule
